// ===== design/wfsa_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// wfsa_pkg: shared types and constants of the weighted fair-share arbiter
// Widths of weights, service counters, sums and keys, and the reset table.
// ---------------------------------------------------------------------------
package wfsa_pkg;

  // Number of requesters (2..8).
  localparam int REQUESTERS  = 6;
  localparam int WEIGHT_REGS = 6;   // weight registers on the config port
  localparam int MASK_W      = 6;   // runnable_mask field width
  localparam int IDX_W       = 3;   // grant_index field width
  localparam int WT_W        = 8;
  localparam int CNT_W       = 32;
  localparam int CFG_IDX_W   = $clog2(WEIGHT_REGS);
  localparam int CFG_DATA_W  = WT_W;
  localparam int TDATA_W     = 8;

  // Sum of all counters and sum of runnable weights, without overflow.
  localparam int RSUM_W = CNT_W + $clog2(REQUESTERS);
  localparam int WSUM_W = WT_W + $clog2(REQUESTERS);
  localparam int PW_W   = WT_W + RSUM_W;
  localparam int PC_W   = CNT_W + WSUM_W;
  localparam int KEY_W  = ((PW_W > PC_W) ? PW_W : PC_W) + 1;

  // Compare tree size.
  localparam int LVL   = $clog2(REQUESTERS);
  localparam int SLOTS = 1 << LVL;

  // Register index of weight_0; weight_i sits at REG_WEIGHT_0 + i.
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_0 = '0;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef logic [WT_W-1:0]         wt_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [RSUM_W-1:0]       rsum_t;
  typedef logic [WSUM_W-1:0]       wsum_t;
  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } pick_t;

  function automatic wt_t weight_reset(input int unsigned i);
    wt_t v;
    case (i)
      0:       v = 8'd50;
      1:       v = 8'd25;
      2:       v = 8'd12;
      3:       v = 8'd8;
      4:       v = 8'd4;
      5:       v = 8'd1;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== design/wfsa_key.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// wfsa_key: fair-share key of one requester
// key = weight * R - count * W, both products unsigned, result signed.
// ---------------------------------------------------------------------------
module wfsa_key (
  input  wire wfsa_pkg::wt_t   weight_i,
  input  wire wfsa_pkg::cnt_t  count_i,
  input  wire wfsa_pkg::rsum_t rsum_i,
  input  wire wfsa_pkg::wsum_t wsum_i,
  output wfsa_pkg::key_t       key_o
);

  logic [wfsa_pkg::PW_W-1:0] prod_w;
  logic [wfsa_pkg::PC_W-1:0] prod_c;

  assign prod_w = wfsa_pkg::PW_W'(weight_i) * wfsa_pkg::PW_W'(rsum_i);
  assign prod_c = wfsa_pkg::PC_W'(count_i) * wfsa_pkg::PC_W'(wsum_i);

  assign key_o = signed'(wfsa_pkg::KEY_W'(prod_w)) - signed'(wfsa_pkg::KEY_W'(prod_c));

endmodule
`default_nettype wire

// ===== design/wfsa_pick.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// wfsa_pick: largest-key compare tree
// Binary tournament over the runnable requesters; lower index wins ties.
// ---------------------------------------------------------------------------
module wfsa_pick (
  input  wire wfsa_pkg::key_t                  key_i [wfsa_pkg::REQUESTERS],
  input  wire [wfsa_pkg::REQUESTERS-1:0]       run_i,
  output wfsa_pkg::pick_t                      pick_o
);

  wfsa_pkg::key_t               lk [wfsa_pkg::LVL+1][wfsa_pkg::SLOTS];
  logic                         lv [wfsa_pkg::LVL+1][wfsa_pkg::SLOTS];
  logic [wfsa_pkg::IDX_W-1:0]   li [wfsa_pkg::LVL+1][wfsa_pkg::SLOTS];

  always_comb begin
    logic take_r;
    for (int l = 0; l <= wfsa_pkg::LVL; l++) begin
      for (int n = 0; n < wfsa_pkg::SLOTS; n++) begin
        lk[l][n] = '0;
        lv[l][n] = 1'b0;
        li[l][n] = '0;
      end
    end
    for (int i = 0; i < wfsa_pkg::REQUESTERS; i++) begin
      lk[0][i] = key_i[i];
      lv[0][i] = run_i[i];
      li[0][i] = wfsa_pkg::IDX_W'(i);
    end
    for (int l = 0; l < wfsa_pkg::LVL; l++) begin
      for (int n = 0; n < (wfsa_pkg::SLOTS >> (l + 1)); n++) begin
        // right side only on a strictly larger key
        take_r = lv[l][2*n+1] && (!lv[l][2*n] || (lk[l][2*n+1] > lk[l][2*n]));
        lk[l+1][n] = take_r ? lk[l][2*n+1] : lk[l][2*n];
        li[l+1][n] = take_r ? li[l][2*n+1] : li[l][2*n];
        lv[l+1][n] = lv[l][2*n] || lv[l][2*n+1];
      end
    end
  end

  assign pick_o.found = lv[wfsa_pkg::LVL][0];
  assign pick_o.idx   = lv[wfsa_pkg::LVL][0] ? li[wfsa_pkg::LVL][0] : '0;

endmodule
`default_nettype wire

// ===== design/weighted_fair_share_arbiter_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// weighted_fair_share_arbiter_unit: weighted fair-share grant arbiter
// Grants the runnable requester furthest behind its weighted share.
// ---------------------------------------------------------------------------
// Each input word carries a runnable mask and a clear flag; each produces
// exactly one output word with grant_valid and grant_index. The block keeps
// a 32-bit saturating service counter per requester and a running total R
// of all counters. With W the sum of runnable weights, it grants the
// runnable requester with the largest weight*max(R,1) - count*max(W,1),
// lowest index on ties, then bumps that counter. Throughput is one word per
// clock while out_tready holds; a word passes the input register and then
// the output register before out_tvalid rises. The rate is set by the
// counter read-modify-write loop: key multipliers, compare tree and counter
// update all complete between the input register and the output register,
// so the next word already sees the new counts. With the output word stalled
// and a second word waiting in the input register, in_tready drops until
// out_tready frees the output register. The user must write weights through
// cfg_* only while the block is idle; the block does not enforce it. Indexes
// beyond weight_5 are dropped. Counters reset to zero with no clearing pass.
// ---------------------------------------------------------------------------
module weighted_fair_share_arbiter_unit (
  input  wire                               clk,
  input  wire                               rst_n,
  // in_tdata: [5:0] runnable_mask, [6] clear_service, [7] zero
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire [wfsa_pkg::TDATA_W-1:0]       in_tdata,
  // out_tdata: [0] grant_valid, [3:1] grant_index, [7:4] zero
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [wfsa_pkg::TDATA_W-1:0]      out_tdata,
  input  wire                               cfg_wr_en,
  input  wire [wfsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [wfsa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int N = wfsa_pkg::REQUESTERS;

  // input stage
  logic                        s1_vld_r, s1_vld_nxt;
  logic [wfsa_pkg::MASK_W-1:0] s1_mask_r;
  logic                        s1_clr_r;

  // output stage
  logic                        out_vld_r, out_vld_nxt;
  logic                        out_gv_r;
  logic [wfsa_pkg::IDX_W-1:0]  out_gi_r;

  // state
  wfsa_pkg::wt_t   weight_r [wfsa_pkg::WEIGHT_REGS];
  wfsa_pkg::cnt_t  cnt_r    [N];
  wfsa_pkg::cnt_t  cnt_nxt  [N];
  wfsa_pkg::rsum_t rsum_r, rsum_nxt;

  // per-word datapath
  logic              advance;
  logic              fire;
  logic [N-1:0]      run;
  logic [N-1:0]      inc;
  wfsa_pkg::wt_t     wt      [N];
  wfsa_pkg::cnt_t    cnt_eff [N];
  wfsa_pkg::key_t    key     [N];
  wfsa_pkg::rsum_t   rsum_raw, rsum_use;
  wfsa_pkg::wsum_t   wsum, wsum_use;
  wfsa_pkg::pick_t   pick;

  // Output register frees up when empty or taken; input stage follows it.
  assign advance   = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || advance;
  assign fire      = s1_vld_r && advance;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_tvalid && in_tready) begin
      s1_vld_nxt = 1'b1;
    end else if (advance) begin
      s1_vld_nxt = 1'b0;
    end
  end

  assign out_vld_nxt = advance ? s1_vld_r : out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_mask_r <= in_tdata[wfsa_pkg::MASK_W-1:0];
      s1_clr_r  <= in_tdata[wfsa_pkg::MASK_W];
    end
  end

  // Clear applies before the choice: counts and total read as zero.
  assign rsum_raw = s1_clr_r ? '0 : rsum_r;
  assign rsum_use = (rsum_raw == '0) ? wfsa_pkg::RSUM_W'(1) : rsum_raw;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_lane
      // mask bits past the field and weights past the registers read as zero
      if (g < wfsa_pkg::MASK_W) begin : g_run
        assign run[g] = s1_mask_r[g];
      end else begin : g_norun
        assign run[g] = 1'b0;
      end
      if (g < wfsa_pkg::WEIGHT_REGS) begin : g_wt
        assign wt[g] = weight_r[g];
      end else begin : g_nowt
        assign wt[g] = '0;
      end

      assign cnt_eff[g] = s1_clr_r ? '0 : cnt_r[g];

      wfsa_key u_key (
        .weight_i (wt[g]),
        .count_i  (cnt_eff[g]),
        .rsum_i   (rsum_use),
        .wsum_i   (wsum_use),
        .key_o    (key[g])
      );

      assign inc[g] = pick.found && (pick.idx == wfsa_pkg::IDX_W'(g)) &&
                      (cnt_eff[g] != wfsa_pkg::CNT_MAX);
      assign cnt_nxt[g] = inc[g] ? (cnt_eff[g] + 1'b1) : cnt_eff[g];
    end
  endgenerate

  always_comb begin
    wsum = '0;
    for (int i = 0; i < N; i++) begin
      wsum = wsum + (run[i] ? wfsa_pkg::WSUM_W'(wt[i]) : '0);
    end
  end
  assign wsum_use = (wsum == '0) ? wfsa_pkg::WSUM_W'(1) : wsum;

  wfsa_pick u_pick (
    .key_i  (key),
    .run_i  (run),
    .pick_o (pick)
  );

  // running total tracks the counters, including saturation
  assign rsum_nxt = (|inc) ? (rsum_raw + 1'b1) : rsum_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        cnt_r[i] <= '0;
      end
      rsum_r <= '0;
    end else if (fire) begin
      for (int i = 0; i < N; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
      rsum_r <= rsum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < wfsa_pkg::WEIGHT_REGS; i++) begin
        weight_r[i] <= wfsa_pkg::weight_reset(i);
      end
    end else if (cfg_wr_en) begin
      for (int i = 0; i < wfsa_pkg::WEIGHT_REGS; i++) begin
        if (cfg_index == (wfsa_pkg::REG_WEIGHT_0 + wfsa_pkg::CFG_IDX_W'(i))) begin
          weight_r[i] <= cfg_wdata[wfsa_pkg::WT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_gv_r <= pick.found;
      out_gi_r <= pick.idx;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(wfsa_pkg::TDATA_W - wfsa_pkg::IDX_W - 1){1'b0}}, out_gi_r, out_gv_r};

endmodule
`default_nettype wire

// ===== design/wfsa_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// wfsa_checker: port-level checks of the fair-share arbiter
// Watches the top level's ports; attached by the bind below.
// ---------------------------------------------------------------------------
module wfsa_checker (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               in_tready,
  input wire                               out_tvalid,
  input wire                               out_tready,
  input wire [wfsa_pkg::TDATA_W-1:0]       out_tdata
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // no grant means index zero
  a_nogrant_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[3:1] == '0)
    else $error("index set without a grant");

  // granted index is a real requester
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |->
      {1'b0, out_tdata[3:1]} < (wfsa_pkg::IDX_W + 1)'(wfsa_pkg::REQUESTERS))
    else $error("grant to a requester that does not exist");

  // empty output register never blocks the input
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with the output empty");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind weighted_fair_share_arbiter_unit wfsa_checker u_wfsa_checker (.*);
`default_nettype wire
